@@ design/ngc_pkg.sv @@
// Package for the cosine-series Green's function unit.
// Holds the fixed-point constants, table channel codes and shared types.
// No dependencies.
package ngc_pkg;

	localparam int IDX_W   = 10;
	localparam int STEP_W  = 25;
	localparam int PHASE_W = 25;
	localparam int COS_W   = 24;
	localparam int WT_W    = 36;
	localparam int ACC_W   = 40;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 2'd1;

	// Weight numerators, 2/pi^2 and 4/pi^2 in Q0.36.
	localparam logic [WT_W-1:0] WT_EDGE  = 36'd13925477443;
	localparam logic [WT_W-1:0] WT_INNER = 36'd27850954887;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 40'sh80_0000_0000;

	// Cosine table channels.
	localparam logic [1:0] CH_SRC_X = 2'd0;
	localparam logic [1:0] CH_SRC_Y = 2'd1;
	localparam logic [1:0] CH_FLD_X = 2'd2;
	localparam logic [1:0] CH_FLD_Y = 2'd3;

	// One write into the cosine tables.
	typedef struct packed {
		logic                    we;
		logic [1:0]              ch;
		logic signed [COS_W-1:0] data;
	} tbl_wr_t;

endpackage

@@ design/ngc_cos_unit.sv @@
// Iterative cosine unit: quarter-wave fold and an even polynomial in Horner form.
// One 31x31 multiplier is reused for the square and every Horner step.
// Depends on ngc_pkg.
module ngc_cos_unit import ngc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [PHASE_W-1:0]       phase,
	output logic                     busy,
	output logic                     done,
	output logic signed [COS_W-1:0]  cos_val
);

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	logic [3:0]  cnt_q;
	logic [23:0] u_q;
	logic        neg_q;
	logic [30:0] w_q;
	logic [30:0] a_q;

	logic [1:0]  quad;
	logic [23:0] u_next;
	logic [30:0] op_a, op_b;
	logic [61:0] prod;
	logic [2:0]  coef_idx;
	logic signed [33:0] diff;
	logic [30:0] a_next;
	logic [31:0] rnd;

	function automatic logic [30:0] coef_at(input logic [2:0] k);
		logic [30:0] c;
		case (k)
			3'd0:    c = 31'd1073741824;
			3'd1:    c = 31'd1324675879;
			3'd2:    c = 31'd272375560;
			3'd3:    c = 31'd22401992;
			3'd4:    c = 31'd987048;
			3'd5:    c = 31'd27060;
			default: c = 31'd506;
		endcase
		return c;
	endfunction

	always_comb begin
		quad   = phase[24:23];
		u_next = quad[0] ? (24'h80_0000 - {1'b0, phase[22:0]}) : {1'b0, phase[22:0]};
		op_a   = (cnt_q == 4'd1) ? {7'd0, u_q} : a_q;
		op_b   = (cnt_q == 4'd1) ? {7'd0, u_q} : w_q;
		prod   = op_a * op_b;
		coef_idx = 3'(4'd7 - cnt_q);
		diff   = $signed({3'b000, coef_at(coef_idx)}) - $signed({2'b00, prod[61:30]});
		if (diff < 0) begin
			a_next = '0;
		end else if (diff > $signed({3'b000, ONE_Q30})) begin
			a_next = ONE_Q30;
		end else begin
			a_next = diff[30:0];
		end
		rnd = ({1'b0, a_q} + 32'd128) >> 8;
	end

	assign busy    = (cnt_q != 4'd0);
	assign done    = (cnt_q == 4'd8);
	assign cos_val = neg_q ? -$signed(rnd[COS_W-1:0]) : $signed(rnd[COS_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (cnt_q == 4'd0) begin
			if (start) begin
				cnt_q <= 4'd1;
			end
		end else if (cnt_q == 4'd8) begin
			cnt_q <= 4'd0;
		end else begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == 4'd0 && start) begin
			u_q   <= u_next;
			neg_q <= (quad == 2'd1) || (quad == 2'd2);
		end else if (cnt_q == 4'd1) begin
			w_q <= prod[46:16];
			a_q <= coef_at(3'd6);
		end else if (cnt_q != 4'd0 && cnt_q != 4'd8) begin
			a_q <= a_next;
		end
	end

endmodule

@@ design/ngc_weight_rom.sv @@
// Mode weight ROM, indexed by the mode pair, with a registered read.
// Entries are worked out at elaboration. Depends on ngc_pkg.
module ngc_weight_rom import ngc_pkg::*; #(
	parameter int MODES = 50
) (
	input  logic                      clk,
	input  logic [$clog2(MODES)-1:0]  m,
	input  logic [$clog2(MODES)-1:0]  n,
	output logic [WT_W-1:0]           wt
);

	logic [WT_W-1:0] rom_tab [MODES][MODES];

	for (genvar gm = 0; gm < MODES; gm++) begin : g_row
		for (genvar gn = 0; gn < MODES; gn++) begin : g_col
			localparam int DEN = gm * gm + gn * gn + ((gm == 0 && gn == 0) ? 1 : 0);
			localparam logic [WT_W-1:0] W = (gm == 0 && gn == 0) ? '0 :
				(((gm == 0 || gn == 0) ? WT_EDGE : WT_INNER) / WT_W'(DEN));
			assign rom_tab[gm][gn] = W;
		end
	end

	always_ff @(posedge clk) begin
		wt <= rom_tab[m][n];
	end

endmodule

@@ design/ngc_series_acc.sv @@
// Cosine tables, term pipeline and saturating accumulator of the mode sum.
// Walks every mode pair once per start, one term a cycle.
// Depends on ngc_pkg and ngc_weight_rom.
module ngc_series_acc import ngc_pkg::*; #(
	parameter int MODES = 50
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tbl_wr_t                  tbl_wr,
	input  logic [$clog2(MODES)-1:0] tbl_k,
	input  logic                     start,
	output logic                     done,
	output logic signed [ACC_W-1:0]  acc
);

	localparam int MW = $clog2(MODES);
	localparam logic [MW-1:0] LAST = MW'(MODES - 1);

	logic signed [COS_W-1:0] mem_sx [MODES];
	logic signed [COS_W-1:0] mem_sy [MODES];
	logic signed [COS_W-1:0] mem_fx [MODES];
	logic signed [COS_W-1:0] mem_fy [MODES];

	logic [MW-1:0] m_q, n_q;
	logic          issuing_q;
	logic          v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic          l1_s1, l2_s2, l3_s3, l4_s4, l5_s5;
	logic signed [COS_W-1:0] csx_s1, csy_s1, cfx_s1, cfy_s1;
	logic signed [COS_W-1:0] p1_s2, cfx_s2, cfy_s2, p2_s3, cfy_s3, p3_s4;
	logic [WT_W-1:0] wt_s1, wt_s2, wt_s3, wt_s4;
	logic signed [31:0] term_s5;
	logic signed [ACC_W-1:0] acc_q;
	logic done_q;
	logic signed [ACC_W:0] sum;

	function automatic logic signed [COS_W-1:0] rnd22(input logic signed [47:0] x);
		logic [47:0] mag;
		logic [47:0] r;
		mag = x[47] ? 48'(-x) : 48'(x);
		r   = (mag + 48'd2097152) >> 22;
		return x[47] ? -$signed(r[COS_W-1:0]) : $signed(r[COS_W-1:0]);
	endfunction

	function automatic logic signed [31:0] rnd30(input logic signed [60:0] x);
		logic [60:0] mag;
		logic [60:0] r;
		mag = x[60] ? 61'(-x) : 61'(x);
		r   = (mag + 61'd536870912) >> 30;
		return x[60] ? -$signed(r[31:0]) : $signed(r[31:0]);
	endfunction

	ngc_weight_rom #(.MODES(MODES)) u_rom (
		.clk (clk),
		.m   (m_q),
		.n   (n_q),
		.wt  (wt_s1)
	);

	always_ff @(posedge clk) begin
		if (tbl_wr.we) begin
			unique case (tbl_wr.ch)
				CH_SRC_X: mem_sx[tbl_k] <= tbl_wr.data;
				CH_SRC_Y: mem_sy[tbl_k] <= tbl_wr.data;
				CH_FLD_X: mem_fx[tbl_k] <= tbl_wr.data;
				CH_FLD_Y: mem_fy[tbl_k] <= tbl_wr.data;
				default: ;
			endcase
		end
		csx_s1 <= mem_sx[n_q];
		cfx_s1 <= mem_fx[n_q];
		csy_s1 <= mem_sy[m_q];
		cfy_s1 <= mem_fy[m_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			m_q <= '0;
			n_q <= '0;
			{v1_s1, v2_s2, v3_s3, v4_s4, v5_s5} <= '0;
			{l1_s1, l2_s2, l3_s3, l4_s4, l5_s5} <= '0;
			done_q <= 1'b0;
			acc_q  <= '0;
		end else begin
			if (start) begin
				issuing_q <= 1'b1;
				m_q <= '0;
				n_q <= '0;
				acc_q <= '0;
			end else if (issuing_q) begin
				if (n_q == LAST) begin
					n_q <= '0;
					m_q <= m_q + 1'b1;
					if (m_q == LAST) begin
						issuing_q <= 1'b0;
					end
				end else begin
					n_q <= n_q + 1'b1;
				end
			end
			v1_s1 <= issuing_q;
			l1_s1 <= issuing_q && (n_q == LAST) && (m_q == LAST);
			{v2_s2, v3_s3, v4_s4, v5_s5} <= {v1_s1, v2_s2, v3_s3, v4_s4};
			{l2_s2, l3_s3, l4_s4, l5_s5} <= {l1_s1, l2_s2, l3_s3, l4_s4};
			if (v5_s5) begin
				if (sum[ACC_W] != sum[ACC_W-1]) begin
					acc_q <= sum[ACC_W] ? ACC_MIN : ACC_MAX;
				end else begin
					acc_q <= sum[ACC_W-1:0];
				end
			end
			done_q <= v5_s5 && l5_s5;
		end
	end

	always_ff @(posedge clk) begin
		p1_s2   <= rnd22(csx_s1 * csy_s1);
		cfx_s2  <= cfx_s1;
		cfy_s2  <= cfy_s1;
		wt_s2   <= wt_s1;
		p2_s3   <= rnd22(p1_s2 * cfx_s2);
		cfy_s3  <= cfy_s2;
		wt_s3   <= wt_s2;
		p3_s4   <= rnd22(p2_s3 * cfy_s3);
		wt_s4   <= wt_s3;
		term_s5 <= rnd30($signed({1'b0, wt_s4}) * p3_s4);
	end

	assign sum  = {acc_q[ACC_W-1], acc_q} + {{(ACC_W - 31){term_s5[31]}}, term_s5};
	assign done = done_q;
	assign acc  = acc_q;

endmodule

@@ design/neumann_green_cosine_series.sv @@
// Top level of the Neumann Green's function unit for the unit square.
// Sequencer, configuration registers and result register. Depends on ngc_pkg,
// ngc_cos_unit and ngc_series_acc.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   in      | in_valid / in_ready  | field_col, field_row, source_col, source_row
//   out     | out_valid / out_ready| green_value (signed Q11.28)
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (step_x = 0, step_y = 1)
//
// The cosine tables come first: 4*MODES cosines, one after another through the one
// iterative cosine unit. The mode sum then feeds one term a cycle into the pipeline.
// After reset both steps hold 16384 and the block is idle; in_ready is high only
// when idle. A result waiting on out_ready does not block the next item's intake,
// but a finished sum waits in the done state until the result register is free.
module neumann_green_cosine_series import ngc_pkg::*; #(
	parameter int MODES       = 50,
	parameter int GRID_POINTS = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [IDX_W-1:0]         field_col,
	input  logic [IDX_W-1:0]         field_row,
	input  logic [IDX_W-1:0]         source_col,
	input  logic [IDX_W-1:0]         source_row,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [ACC_W-1:0]  green_value,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [STEP_W-1:0]        cfg_data
);

	localparam int MW = $clog2(MODES);
	localparam logic [MW-1:0] LAST = MW'(MODES - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_TABLE = 4'b0010,
		ST_SUM   = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0]  step_x_q, step_y_q;
	logic [PHASE_W-1:0] base_q [4];
	logic [PHASE_W-1:0] ph_q [4];
	logic [1:0]         ch_q;
	logic [MW-1:0]      k_q;
	logic               pend_q;
	logic               out_valid_q;
	logic signed [ACC_W-1:0] green_q;

	logic [IDX_W+STEP_W-1:0] pos_fx, pos_fy, pos_sx, pos_sy;
	logic cos_start, cos_busy, cos_done;
	logic signed [COS_W-1:0] cos_val;
	tbl_wr_t tbl_wr;
	logic ser_start, ser_done;
	logic signed [ACC_W-1:0] ser_acc;

	// Indices past the grid are held at the last grid point.
	function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
		logic [IDX_W-1:0] r;
		r = v;
		if (int'(v) > GRID_POINTS - 1) begin
			r = IDX_W'(GRID_POINTS - 1);
		end
		return r;
	endfunction

	assign pos_fx = clamp_idx(field_col)  * step_x_q;
	assign pos_fy = clamp_idx(field_row)  * step_y_q;
	assign pos_sx = clamp_idx(source_col) * step_x_q;
	assign pos_sy = clamp_idx(source_row) * step_y_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	// A new cosine is issued only when the cosine unit is idle.
	assign cos_start = (state_q == ST_TABLE) && !pend_q && !cos_busy;
	assign ser_start = (state_q == ST_TABLE) && cos_done && (ch_q == CH_FLD_Y) && (k_q == LAST);

	always_comb begin
		tbl_wr.we   = (state_q == ST_TABLE) && cos_done;
		tbl_wr.ch   = ch_q;
		tbl_wr.data = cos_val;
	end

	ngc_cos_unit u_cos (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cos_start),
		.phase   (ph_q[ch_q]),
		.busy    (cos_busy),
		.done    (cos_done),
		.cos_val (cos_val)
	);

	ngc_series_acc #(.MODES(MODES)) u_series (
		.clk    (clk),
		.arst_n (arst_n),
		.tbl_wr (tbl_wr),
		.tbl_k  (k_q),
		.start  (ser_start),
		.done   (ser_done),
		.acc    (ser_acc)
	);

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q <= 25'd16384;
			step_y_q <= 25'd16384;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP_X: step_x_q <= cfg_data;
				REG_STEP_Y: step_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer. The channel order of each table row is source x, source y,
	// field x, field y; every phase steps by its base once its cosine is done,
	// which keeps k times the position modulo one turn with no multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= CH_SRC_X;
			k_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register is loaded from the done state when it is free
			// or being read in the same cycle.
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_TABLE;
						ch_q    <= CH_SRC_X;
						k_q     <= '0;
						pend_q  <= 1'b0;
					end
				end
				ST_TABLE: begin
					if (cos_start) begin
						pend_q <= 1'b1;
					end else if (cos_done) begin
						pend_q <= 1'b0;
						ch_q   <= ch_q + 2'd1;
						if (ch_q == CH_FLD_Y) begin
							k_q <= k_q + 1'b1;
							if (k_q == LAST) begin
								state_q <= ST_SUM;
							end
						end
					end
				end
				ST_SUM: begin
					if (ser_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			base_q[CH_SRC_X] <= pos_sx[PHASE_W-1:0];
			base_q[CH_SRC_Y] <= pos_sy[PHASE_W-1:0];
			base_q[CH_FLD_X] <= pos_fx[PHASE_W-1:0];
			base_q[CH_FLD_Y] <= pos_fy[PHASE_W-1:0];
			for (int i = 0; i < 4; i++) begin
				ph_q[i] <= '0;
			end
		end else if (state_q == ST_TABLE && cos_done) begin
			ph_q[ch_q] <= ph_q[ch_q] + base_q[ch_q];
		end
		// The result is the negated sum; the most negative sum saturates.
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			green_q <= (ser_acc == ACC_MIN) ? ACC_MAX : -ser_acc;
		end
	end

	assign out_valid   = out_valid_q;
	assign green_value = green_q;

endmodule

@@ tb/tb_neumann_green_cosine_series.sv @@
// Self-checking testbench for the Neumann Green's function cosine-series unit.
// Predicts every green_value from the steps and indexes of each item and compares
// it with the block's result. Depends on ngc_pkg and neumann_green_cosine_series.
module tb_neumann_green_cosine_series;
	import ngc_pkg::*;

	localparam int MODES = 50;
	localparam int GRID_POINTS = 1024;
	// About 240 items, plus the long hold-off and the idle gaps, fit well inside
	// this bound.
	localparam longint CYCLE_LIMIT = 4_000_000;
	localparam int HOLD_OFF_CYCLES = 20000;
	localparam int SETTLE_CYCLES = 100;
	// Register indexes that the block does not decode; writes to them are ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
	localparam longint unsigned PHASE_MASK = 64'h1FF_FFFF;
	localparam longint unsigned QUARTER = 64'h80_0000;
	localparam longint COS_ONE = 64'd1073741824;
	localparam longint POLY_COEF [0:6] = '{1073741824, 1324675879, 272375560,
		22401992, 987048, 27060, 506};

	typedef struct packed {
		logic [IDX_W-1:0] fcol;
		logic [IDX_W-1:0] frow;
		logic [IDX_W-1:0] scol;
		logic [IDX_W-1:0] srow;
	} point_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [IDX_W-1:0] field_col = '0;
	logic [IDX_W-1:0] field_row = '0;
	logic [IDX_W-1:0] source_col = '0;
	logic [IDX_W-1:0] source_row = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [ACC_W-1:0] green_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [STEP_W-1:0] cfg_data = '0;

	neumann_green_cosine_series #(.MODES(MODES), .GRID_POINTS(GRID_POINTS)) dut (.*);

	always #2 clk = ~clk;

	point_pair_t pending_pairs [$];
	logic signed [ACC_W-1:0] expected_green [$];
	// The predictor's own copy of the two step registers.
	logic [STEP_W-1:0] model_step_x = 25'd16384;
	logic [STEP_W-1:0] model_step_y = 25'd16384;
	logic failed = 1'b0;
	longint cycles = 0;
	int results_seen = 0;
	logic in_took = 1'b0;
	int send_gap = 0;
	bit send_steady = 1'b0;
	int send_count = 0;
	int recv_wait = 0;
	bit hold_done = 1'b0;

	// Cosine of a phase where 2^24 stands for pi, in Q1.22. The phase is folded
	// into the first quadrant and an even polynomial is evaluated by Horner's rule.
	function automatic longint cos_of_phase(longint unsigned phase);
		longint unsigned p, r, u;
		logic [1:0] quad;
		longint w, a;
		p = phase & PHASE_MASK;
		quad = p[24:23];
		r = p & (QUARTER - 1);
		u = quad[0] ? (QUARTER - r) : r;
		w = longint'((u * u) >> 16);
		a = POLY_COEF[6];
		for (int k = 5; k >= 0; k--) begin
			a = POLY_COEF[k] - ((a * w) >>> 30);
			if (a < 0) a = 0;
			if (a > COS_ONE) a = COS_ONE;
		end
		a = (a + 128) >>> 8;
		return (quad == 2'd1 || quad == 2'd2) ? -a : a;
	endfunction

	function automatic longint round_away(longint x, int s);
		longint unsigned mag;
		mag = (x < 0) ? longint'(-x) : x;
		mag = (mag + (longint'(1) << (s - 1))) >> s;
		return (x < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint unsigned grid_position(logic [IDX_W-1:0] idx,
			logic [STEP_W-1:0] step);
		longint unsigned i;
		i = idx;
		if (i > GRID_POINTS - 1) i = GRID_POINTS - 1;
		return (i * step) & PHASE_MASK;
	endfunction

	// Negated, saturated mode sum for one point pair under the given steps.
	function automatic logic signed [ACC_W-1:0] green_sum(point_pair_t pp,
			logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy);
		longint cfx [MODES], cfy [MODES], csx [MODES], csy [MODES];
		longint unsigned bfx, bfy, bsx, bsy;
		longint acc, wt, prod, den;
		bfx = grid_position(pp.fcol, sx);
		bfy = grid_position(pp.frow, sy);
		bsx = grid_position(pp.scol, sx);
		bsy = grid_position(pp.srow, sy);
		for (int k = 0; k < MODES; k++) begin
			cfx[k] = cos_of_phase(k * bfx);
			cfy[k] = cos_of_phase(k * bfy);
			csx[k] = cos_of_phase(k * bsx);
			csy[k] = cos_of_phase(k * bsy);
		end
		acc = 0;
		for (int m = 0; m < MODES; m++) begin
			for (int n = 0; n < MODES; n++) begin
				den = n * n + m * m;
				if (den != 0) begin
					wt = ((n == 0 || m == 0) ? longint'(WT_EDGE) : longint'(WT_INNER)) / den;
					prod = round_away(csx[n] * csy[m], 22);
					prod = round_away(prod * cfx[n], 22);
					prod = round_away(prod * cfy[m], 22);
					acc += round_away(wt * prod, 30);
					if (acc > longint'(ACC_MAX)) acc = ACC_MAX;
					if (acc < longint'(ACC_MIN)) acc = ACC_MIN;
				end
			end
		end
		acc = (acc == longint'(ACC_MIN)) ? longint'(ACC_MAX) : -acc;
		return acc[ACC_W-1:0];
	endfunction

	function automatic point_pair_t random_pair();
		point_pair_t pp;
		pp = 40'({$urandom, $urandom});
		// Now and then pin single indexes to the edges of the grid.
		if ($urandom_range(0, 5) == 0) pp.fcol = $urandom_range(0, 1) ? '1 : '0;
		if ($urandom_range(0, 5) == 0) pp.srow = $urandom_range(0, 1) ? '1 : '0;
		return pp;
	endfunction

	// Prediction and checking, all on the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_took <= in_valid && in_ready;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_green.size());
			$display("tb_neumann_green_cosine_series NOT OK");
			$finish;
		end
		if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_STEP_X) model_step_x <= cfg_data;
			else if (cfg_index == REG_STEP_Y) model_step_y <= cfg_data;
		end
		if (in_valid && in_ready)
			expected_green.push_back(green_sum({field_col, field_row, source_col,
				source_row}, model_step_x, model_step_y));
		if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_green.size() == 0) begin
				$display("%0t: unexpected result, actual %0d", $time, green_value);
				failed <= 1'b1;
			end else begin
				if (green_value !== expected_green[0]) begin
					$display("%0t: green_value expected %0d actual %0d", $time,
						expected_green[0], green_value);
					failed <= 1'b1;
				end
				void'(expected_green.pop_front());
			end
		end
	end

	// Sender: offers the queued items with random gaps, switching now and then to
	// a steady stream with no gaps at all.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_took)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_pairs.size() > 0) begin
				point_pair_t pp;
				pp = pending_pairs.pop_front();
				{field_col, field_row, source_col, source_row} <= pp;
				in_valid <= 1'b1;
				send_count <= send_count + 1;
				if (send_count % 30 == 0) send_steady <= $urandom_range(0, 2) == 0;
				send_gap <= send_steady ? 0 : $urandom_range(0, 19);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a random stall before each result, and once a long hold-off so
	// that a finished sum backs up and the block stops taking items.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				out_ready <= 1'b0;
				if (results_seen >= 2 && !hold_done) begin
					recv_wait <= HOLD_OFF_CYCLES;
					hold_done <= 1'b1;
				end else begin
					recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
				end
			end else if (recv_wait > 0) begin
				out_ready <= 1'b0;
				recv_wait <= recv_wait - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready)) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every item has gone in and every result has come out, then
	// lets the block settle before the registers change.
	task automatic drain();
		wait (pending_pairs.size() == 0 && !in_valid && expected_green.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_steps(logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy);
		drain();
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
	endtask

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++) pending_pairs.push_back(random_pair());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default steps, plus writes to the undecoded indexes, which must change
		// nothing.
		write_reg(REG_STEP_X, 25'd16384);
		write_reg(REG_UNUSED_A, '1);
		write_reg(REG_STEP_Y, 25'd16384);
		write_reg(REG_UNUSED_B, 25'h0AA_AAAA);
		// Directed pairs: corners of the index range, alternating bit patterns,
		// and the field point on top of the source point.
		pending_pairs.push_back('{10'd0, 10'd0, 10'd0, 10'd0});
		pending_pairs.push_back('{10'd1023, 10'd1023, 10'd1023, 10'd1023});
		pending_pairs.push_back('{10'd0, 10'd1023, 10'd1023, 10'd0});
		pending_pairs.push_back('{10'h2AA, 10'h155, 10'h155, 10'h2AA});
		pending_pairs.push_back('{10'h155, 10'h2AA, 10'h2AA, 10'h155});
		pending_pairs.push_back('{10'd512, 10'd512, 10'd512, 10'd512});
		pending_pairs.push_back('{10'd1, 10'd2, 10'd1, 10'd2});
		pending_pairs.push_back('{10'd1022, 10'd3, 10'd7, 10'd1000});

		// A zero step puts every point at the origin, where all cosines are one.
		set_steps(25'd0, 25'd0);
		pending_pairs.push_back('{10'd1023, 10'd5, 10'd17, 10'd0});
		pending_pairs.push_back('{10'd0, 10'd0, 10'd0, 10'd0});

		// A step of one full unit and the largest step, past the unit square.
		set_steps(25'h100_0000, 25'h1FF_FFFF);
		pending_pairs.push_back('{10'd1, 10'd1, 10'd0, 10'd0});
		pending_pairs.push_back('{10'd1023, 10'd1023, 10'd3, 10'd511});
		pending_pairs.push_back('{10'h2AA, 10'h155, 10'h3FF, 10'd1});

		// Smallest nonzero step.
		set_steps(25'd1, 25'd1);
		pending_pairs.push_back('{10'd1023, 10'd1023, 10'd0, 10'd1});
		pending_pairs.push_back('{10'd12, 10'd900, 10'd345, 10'd6});

		// Random pairs under the default step.
		set_steps(25'd16384, 25'd16384);
		queue_random(90);

		// Random pairs under random steps, fine and coarse.
		for (int ph = 0; ph < 7; ph++) begin
			set_steps(STEP_W'($urandom_range(0, 32'h1FF_FFFF)),
				STEP_W'($urandom_range(0, 32'h3_FFFF)));
			queue_random(20);
		end

		drain();
		if (!failed) begin
			$display("tb_neumann_green_cosine_series OK");
		end else begin
			$display("tb_neumann_green_cosine_series NOT OK");
		end
		$finish;
	end

endmodule
